// ===== rtl/lfu_cache_lru_tiebreak_top_assert.svh =====
// Assertion macros shared by the cache RTL.
// Included by lfuc_store and lfu_cache_lru_tiebreak_top; no other dependencies.
`ifndef LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH
`define LFU_CACHE_LRU_TIEBREAK_TOP_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define LFUC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define LFUC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/lfuc_pkg.sv =====
// Shared types and constants for the LFU cache.
// No dependencies.
`default_nettype none

package lfuc_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CAP_REG_W = 5;

    localparam logic [CAP_REG_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                    operation;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] put_value;
    } t_req;

    typedef struct packed {
        logic                    hit;
        logic signed [VAL_W-1:0] read_value;
        logic                    evicted;
        logic signed [KEY_W-1:0] evicted_key;
    } t_rsp;

    // outcome of one scan over all slots
    typedef struct packed {
        logic match;
        logic free;
        logic victim;
    } t_scan_flags;

endpackage

`default_nettype wire

// ===== rtl/lfuc_store.sv =====
// Slot storage: key, value, count and rank memories plus per-slot valid bits.
// One registered read port, one write port per memory. Uses lfuc_pkg.
`default_nettype none

`include "lfu_cache_lru_tiebreak_top_assert.svh"

module lfuc_store #(
    parameter int CAPACITY   = 16,
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4
) (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    // read port
    input  wire                        i_rd_en,
    input  wire  [IDX_W-1:0]           i_rd_idx,
    output logic                       o_rd_vld,
    output logic [IDX_W-1:0]           o_rd_idx,
    output logic                       o_rd_valid_bit,
    output logic [lfuc_pkg::KEY_W-1:0] o_rd_key,
    output logic [lfuc_pkg::VAL_W-1:0] o_rd_value,
    output logic [COUNT_BITS-1:0]      o_rd_count,
    output logic [IDX_W-1:0]           o_rd_rank,
    // rank-only write
    input  wire                        i_rank_we,
    input  wire  [IDX_W-1:0]           i_rank_idx,
    input  wire  [IDX_W-1:0]           i_rank_data,
    // full entry write, rank set to most recent
    input  wire                        i_ent_we,
    input  wire  [IDX_W-1:0]           i_ent_idx,
    input  wire  [lfuc_pkg::KEY_W-1:0] i_ent_key,
    input  wire  [lfuc_pkg::VAL_W-1:0] i_ent_value,
    input  wire  [COUNT_BITS-1:0]      i_ent_count
);

    logic [lfuc_pkg::KEY_W-1:0] r_key_mem   [CAPACITY];
    logic [lfuc_pkg::VAL_W-1:0] r_value_mem [CAPACITY];
    logic [COUNT_BITS-1:0]      r_count_mem [CAPACITY];
    logic [IDX_W-1:0]           r_rank_mem  [CAPACITY];
    logic [CAPACITY-1:0]        r_valid;

    logic                       w_rank_we;
    logic [IDX_W-1:0]           w_rank_addr;
    logic [IDX_W-1:0]           w_rank_wdata;

    // entry writes and rank sweep writes never share a cycle
    assign w_rank_we    = i_rank_we | i_ent_we;
    assign w_rank_addr  = i_ent_we ? i_ent_idx : i_rank_idx;
    assign w_rank_wdata = i_ent_we ? '0 : i_rank_data;

    always_ff @(posedge i_clk) begin
        if (i_ent_we) begin
            r_key_mem[i_ent_idx]   <= i_ent_key;
            r_value_mem[i_ent_idx] <= i_ent_value;
            r_count_mem[i_ent_idx] <= i_ent_count;
        end
        if (w_rank_we) begin
            r_rank_mem[w_rank_addr] <= w_rank_wdata;
        end
        if (i_rd_en) begin
            o_rd_idx       <= i_rd_idx;
            o_rd_valid_bit <= r_valid[i_rd_idx];
            o_rd_key       <= r_key_mem[i_rd_idx];
            o_rd_value     <= r_value_mem[i_rd_idx];
            o_rd_count     <= r_count_mem[i_rd_idx];
            o_rd_rank      <= r_rank_mem[i_rd_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            o_rd_vld <= 1'b0;
        end else begin
            o_rd_vld <= i_rd_en;
            if (i_ent_we) begin
                r_valid[i_ent_idx] <= 1'b1;
            end
        end
    end

    `LFUC_ASSERT_NOW(a_rank_wr_valid, i_clk, i_rst_n, i_rank_we, r_valid[i_rank_idx], "rank write to empty slot")
    `LFUC_ASSERT_NEXT(a_ent_sets_valid, i_clk, i_rst_n, i_ent_we, r_valid[$past(i_ent_idx)], "entry write left slot invalid")
    `LFUC_ASSERT_NOW(a_wr_no_overlap, i_clk, i_rst_n, i_ent_we, !i_rank_we, "entry and rank writes together")

endmodule

`default_nettype wire

// ===== rtl/lfuc_scan.sv =====
// Shared compare unit: folds one slot per step into match, free-slot,
// occupancy and victim (min count, oldest on tie) results. Uses lfuc_pkg.
`default_nettype none

module lfuc_scan #(
    parameter int COUNT_BITS = 16,
    parameter int IDX_W      = 4,
    parameter int USED_W     = 5
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_clear,
    input  wire                         i_step,
    input  wire  [lfuc_pkg::KEY_W-1:0]  i_key_ref,
    input  wire  [IDX_W-1:0]            i_idx,
    input  wire                         i_valid_bit,
    input  wire  [lfuc_pkg::KEY_W-1:0]  i_key,
    input  wire  [lfuc_pkg::VAL_W-1:0]  i_value,
    input  wire  [COUNT_BITS-1:0]       i_count,
    input  wire  [IDX_W-1:0]            i_rank,
    output lfuc_pkg::t_scan_flags       o_flags,
    output logic [IDX_W-1:0]            o_match_idx,
    output logic [lfuc_pkg::VAL_W-1:0]  o_match_value,
    output logic [COUNT_BITS-1:0]       o_match_count,
    output logic [IDX_W-1:0]            o_match_rank,
    output logic [IDX_W-1:0]            o_free_idx,
    output logic [USED_W-1:0]           o_used,
    output logic [IDX_W-1:0]            o_victim_idx,
    output logic [lfuc_pkg::KEY_W-1:0]  o_victim_key,
    output logic [IDX_W-1:0]            o_victim_rank
);

    logic [COUNT_BITS-1:0] r_victim_count;
    logic                  w_is_match;
    logic                  w_is_free;
    logic                  w_better;

    assign w_is_match = i_valid_bit && (i_key == i_key_ref) && !o_flags.match;
    assign w_is_free  = !i_valid_bit && !o_flags.free;
    // lower count wins; equal count goes to the older (higher rank) slot
    assign w_better   = i_valid_bit &&
                        (!o_flags.victim || (i_count < r_victim_count) ||
                         ((i_count == r_victim_count) && (i_rank > o_victim_rank)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_flags <= '0;
            o_used  <= '0;
        end else if (i_clear) begin
            o_flags <= '0;
            o_used  <= '0;
        end else if (i_step) begin
            if (w_is_match) begin
                o_flags.match <= 1'b1;
            end
            if (w_is_free) begin
                o_flags.free <= 1'b1;
            end
            if (w_better) begin
                o_flags.victim <= 1'b1;
            end
            if (i_valid_bit) begin
                o_used <= o_used + USED_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            if (w_is_match) begin
                o_match_idx   <= i_idx;
                o_match_value <= i_value;
                o_match_count <= i_count;
                o_match_rank  <= i_rank;
            end
            if (w_is_free) begin
                o_free_idx <= i_idx;
            end
            if (w_better) begin
                o_victim_idx   <= i_idx;
                o_victim_key   <= i_key;
                o_victim_rank  <= i_rank;
                r_victim_count <= i_count;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lfu_cache_lru_tiebreak_top.sv =====
// LFU key-value cache with LRU tie-break, top level. Uses lfuc_pkg, lfuc_store
// and lfuc_scan. Each request first sweeps all CAPACITY slots through the
// shared compare unit, one slot per cycle, to find a key match, a free slot and
// the eviction victim. A get miss, or a put while the capacity register is zero,
// then goes from the decide state straight to the done state. Any request that
// changes the store makes a second sweep over the rank memory (one read per
// cycle, with a write for each slot whose rank ages) and then a commit state.
// The slot memories' single read port sets both sweeps. Requests are taken only
// while the sequencer is idle; a finished response sits in the output register
// until taken, and the next request may be accepted meanwhile. No clearing pass
// is needed after reset.
`default_nettype none

`include "lfu_cache_lru_tiebreak_top_assert.svh"

module lfu_cache_lru_tiebreak_top #(
    parameter int CAPACITY   = 16,
    parameter int COUNT_BITS = 16
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_in_valid,
    output logic                             o_in_stall,
    input  lfuc_pkg::t_req                   i_in_data,
    output logic                             o_out_valid,
    input  wire                              i_out_stall,
    output lfuc_pkg::t_rsp                   o_out_data,
    input  wire                              i_cfg_we,
    input  wire  [lfuc_pkg::CAP_REG_W-1:0]   i_cfg_wdata
);

    localparam int IDX_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int USED_W = $clog2(CAPACITY + 1);
    localparam int CAPW   = (USED_W > lfuc_pkg::CAP_REG_W) ? USED_W : lfuc_pkg::CAP_REG_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
    localparam logic [CAPW-1:0]  CAP_MAX  = CAPW'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SCAN_END,
        S_DECIDE,
        S_RANK,
        S_RANK_END,
        S_COMMIT,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [IDX_W-1:0]                r_idx;
    logic [lfuc_pkg::CAP_REG_W-1:0]  r_capacity;
    lfuc_pkg::t_req                  r_req;
    logic                            r_all_inc;
    logic [IDX_W-1:0]                r_pivot;
    logic [IDX_W-1:0]                r_slot;
    logic [lfuc_pkg::VAL_W-1:0]      r_new_value;
    logic [COUNT_BITS-1:0]           r_new_count;
    lfuc_pkg::t_rsp                  r_rsp;

    logic                            n_update;
    logic                            n_all_inc;
    logic [IDX_W-1:0]                n_pivot;
    logic [IDX_W-1:0]                n_slot;
    logic [lfuc_pkg::VAL_W-1:0]      n_new_value;
    logic [COUNT_BITS-1:0]           n_new_count;
    lfuc_pkg::t_rsp                  n_rsp;

    // store read side
    logic                            rd_en;
    logic                            rd_vld;
    logic [IDX_W-1:0]                rd_idx;
    logic                            rd_valid_bit;
    logic [lfuc_pkg::KEY_W-1:0]      rd_key;
    logic [lfuc_pkg::VAL_W-1:0]      rd_value;
    logic [COUNT_BITS-1:0]           rd_count;
    logic [IDX_W-1:0]                rd_rank;

    logic                            rank_we;
    logic                            ent_we;
    logic                            in_accept;
    logic                            out_free;
    logic                            in_rank_pass;

    // scan results
    lfuc_pkg::t_scan_flags           sc_flags;
    logic [IDX_W-1:0]                sc_match_idx;
    logic [lfuc_pkg::VAL_W-1:0]      sc_match_value;
    logic [COUNT_BITS-1:0]           sc_match_count;
    logic [IDX_W-1:0]                sc_match_rank;
    logic [IDX_W-1:0]                sc_free_idx;
    logic [USED_W-1:0]               sc_used;
    logic [IDX_W-1:0]                sc_victim_idx;
    logic [lfuc_pkg::KEY_W-1:0]      sc_victim_key;
    logic [IDX_W-1:0]                sc_victim_rank;

    logic [CAPW-1:0]                 cap_eff;
    logic                            cap_zero;
    logic                            is_put;
    logic                            put_miss;
    logic                            need_evict;
    logic [COUNT_BITS-1:0]           cnt_inc;

    assign in_accept    = i_in_valid && !o_in_stall;
    assign o_in_stall   = (r_state != S_IDLE);
    assign out_free     = !o_out_valid || !i_out_stall;
    assign rd_en        = (r_state == S_SCAN) || (r_state == S_RANK);
    assign in_rank_pass = (r_state == S_RANK) || (r_state == S_RANK_END);
    // touch: slots newer than the pivot age by one; plain insert ages everyone
    assign rank_we      = rd_vld && in_rank_pass && rd_valid_bit &&
                          (r_all_inc || (rd_rank < r_pivot));
    assign ent_we       = (r_state == S_COMMIT);

    assign cap_eff    = (CAPW'(r_capacity) > CAP_MAX) ? CAP_MAX : CAPW'(r_capacity);
    assign cap_zero   = (cap_eff == '0);
    assign is_put     = (r_req.operation == lfuc_pkg::OP_PUT);
    assign put_miss   = is_put && !cap_zero && !sc_flags.match;
    assign need_evict = put_miss && (CAPW'(sc_used) >= cap_eff);
    assign cnt_inc    = (sc_match_count == '1) ? sc_match_count
                                               : sc_match_count + COUNT_BITS'(1);

    always_comb begin
        n_update    = 1'b0;
        n_all_inc   = 1'b0;
        n_pivot     = sc_match_rank;
        n_slot      = sc_match_idx;
        n_new_value = sc_match_value;
        n_new_count = cnt_inc;
        n_rsp       = '0;
        n_rsp.hit   = sc_flags.match;
        if (!is_put) begin
            if (sc_flags.match) begin
                n_update         = 1'b1;
                n_rsp.read_value = sc_match_value;
            end
        end else if (!cap_zero) begin
            n_update    = 1'b1;
            n_new_value = r_req.put_value;
            if (!sc_flags.match) begin
                n_new_count = COUNT_BITS'(1);
                if (need_evict) begin
                    n_pivot           = sc_victim_rank;
                    n_slot            = sc_victim_idx;
                    n_rsp.evicted     = 1'b1;
                    n_rsp.evicted_key = sc_victim_key;
                end else begin
                    n_all_inc = 1'b1;
                    n_slot    = sc_free_idx;
                end
            end
        end
    end

    // sequencer and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= '0;
            r_capacity  <= lfuc_pkg::CAP_RESET;
            o_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
            if (o_out_valid && !i_out_stall && (r_state != S_DONE)) begin
                o_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_state <= S_SCAN;
                        r_idx   <= '0;
                    end
                end
                S_SCAN: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_SCAN_END;
                    end
                end
                S_SCAN_END: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_idx   <= '0;
                    r_state <= n_update ? S_RANK : S_DONE;
                end
                S_RANK: begin
                    r_idx <= r_idx + IDX_W'(1);
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_RANK_END;
                    end
                end
                S_RANK_END: begin
                    r_state <= S_COMMIT;
                end
                S_COMMIT: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        o_out_valid <= 1'b1;
                        o_out_data  <= r_rsp;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_req <= i_in_data;
        end
        if (r_state == S_DECIDE) begin
            r_all_inc   <= n_all_inc;
            r_pivot     <= n_pivot;
            r_slot      <= n_slot;
            r_new_value <= n_new_value;
            r_new_count <= n_new_count;
            r_rsp       <= n_rsp;
        end
    end

    lfuc_store #(
        .CAPACITY   (CAPACITY),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_store (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rd_en        (rd_en),
        .i_rd_idx       (r_idx),
        .o_rd_vld       (rd_vld),
        .o_rd_idx       (rd_idx),
        .o_rd_valid_bit (rd_valid_bit),
        .o_rd_key       (rd_key),
        .o_rd_value     (rd_value),
        .o_rd_count     (rd_count),
        .o_rd_rank      (rd_rank),
        .i_rank_we      (rank_we),
        .i_rank_idx     (rd_idx),
        .i_rank_data    (rd_rank + IDX_W'(1)),
        .i_ent_we       (ent_we),
        .i_ent_idx      (r_slot),
        .i_ent_key      (r_req.key),
        .i_ent_value    (r_new_value),
        .i_ent_count    (r_new_count)
    );

    lfuc_scan #(
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W),
        .USED_W     (USED_W)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_clear        (in_accept),
        .i_step         (rd_vld && !in_rank_pass),
        .i_key_ref      (r_req.key),
        .i_idx          (rd_idx),
        .i_valid_bit    (rd_valid_bit),
        .i_key          (rd_key),
        .i_value        (rd_value),
        .i_count        (rd_count),
        .i_rank         (rd_rank),
        .o_flags        (sc_flags),
        .o_match_idx    (sc_match_idx),
        .o_match_value  (sc_match_value),
        .o_match_count  (sc_match_count),
        .o_match_rank   (sc_match_rank),
        .o_free_idx     (sc_free_idx),
        .o_used         (sc_used),
        .o_victim_idx   (sc_victim_idx),
        .o_victim_key   (sc_victim_key),
        .o_victim_rank  (sc_victim_rank)
    );

    `LFUC_ASSERT_NOW(a_victim_found, i_clk, i_rst_n, (r_state == S_DECIDE) && need_evict, sc_flags.victim, "full store but no victim")
    `LFUC_ASSERT_NOW(a_free_found, i_clk, i_rst_n, (r_state == S_DECIDE) && put_miss && !need_evict, sc_flags.free, "room left but no free slot")
    `LFUC_ASSERT_NOW(a_evict_not_hit, i_clk, i_rst_n, o_out_valid, !(o_out_data.evicted && o_out_data.hit), "eviction on a hit")
    `LFUC_ASSERT_NOW(a_miss_zero_read, i_clk, i_rst_n, o_out_valid && !o_out_data.hit, o_out_data.read_value == '0, "read data on a miss")

endmodule

`default_nettype wire

// ===== test/tb.sv =====
// Testbench for lfu_cache_lru_tiebreak_top: drives get/put requests and capacity writes,
// mirrors the cache in a scoreboard class and checks every response field by field.
// Depends on lfuc_pkg and the cache RTL only.
`timescale 1ns / 100ps

class cache_mirror;
    localparam int SLOTS = 16;
    localparam int unsigned USE_MAX = (1 << 16) - 1;

    bit                             live [SLOTS];
    logic [lfuc_pkg::KEY_W-1:0]     tag  [SLOTS];
    logic [lfuc_pkg::VAL_W-1:0]     data [SLOTS];
    int unsigned                    uses [SLOTS];
    int unsigned                    age  [SLOTS];   // 0 = most recently accessed
    logic [lfuc_pkg::CAP_REG_W-1:0] cap_reg;
    lfuc_pkg::t_rsp                 replies_due[$];
    int                             errors;

    function new();
        cap_reg = lfuc_pkg::CAP_RESET;
        errors  = 0;
        for (int i = 0; i < SLOTS; i++) begin
            live[i] = 1'b0;
            tag[i]  = '0;
            data[i] = '0;
            uses[i] = 0;
            age[i]  = 0;
        end
    endfunction

    function void set_capacity(logic [lfuc_pkg::CAP_REG_W-1:0] v);
        cap_reg = v;
    endfunction

    function int outstanding();
        return replies_due.size();
    endfunction

    function int find_slot(logic [lfuc_pkg::KEY_W-1:0] k);
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && tag[i] == k)
                return i;
        return -1;
    endfunction

    // move a slot to the front of the recency order and bump its count
    function void promote(int s);
        int unsigned r;
        r = age[s];
        for (int i = 0; i < SLOTS; i++)
            if (live[i] && age[i] < r)
                age[i]++;
        age[s] = 0;
        if (uses[s] < USE_MAX)
            uses[s]++;
    endfunction

    function void note_access(lfuc_pkg::t_req r);
        lfuc_pkg::t_rsp want;
        int             s;
        int             spare;
        int             victim;
        int unsigned    fill;
        int unsigned    eff_cap;
        int unsigned    old;
        want    = '0;
        eff_cap = (cap_reg > SLOTS) ? SLOTS : cap_reg;
        s       = find_slot(r.key);
        want.hit = (s >= 0);
        if (r.operation == lfuc_pkg::OP_GET) begin
            if (s >= 0) begin
                want.read_value = data[s];
                promote(s);
            end
        end else if (eff_cap != 0) begin
            if (s >= 0) begin
                data[s] = r.put_value;
                promote(s);
            end else begin
                fill  = 0;
                spare = -1;
                for (int i = 0; i < SLOTS; i++) begin
                    if (live[i])
                        fill++;
                    else if (spare < 0)
                        spare = i;
                end
                if (fill >= eff_cap) begin
                    // lowest count loses; among equal counts the oldest access
                    victim = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (live[i] && (victim < 0 || uses[i] < uses[victim] ||
                            (uses[i] == uses[victim] && age[i] > age[victim])))
                            victim = i;
                    end
                    if (victim >= 0) begin
                        old              = age[victim];
                        want.evicted     = 1'b1;
                        want.evicted_key = tag[victim];
                        live[victim]     = 1'b0;
                        for (int i = 0; i < SLOTS; i++)
                            if (live[i] && age[i] > old)
                                age[i]--;
                        spare = victim;
                    end
                end
                if (spare >= 0) begin
                    for (int i = 0; i < SLOTS; i++)
                        if (live[i])
                            age[i]++;
                    live[spare] = 1'b1;
                    tag[spare]  = r.key;
                    data[spare] = r.put_value;
                    uses[spare] = 1;
                    age[spare]  = 0;
                end
            end
        end
        replies_due.push_back(want);
    endfunction

    task report(string field, logic [31:0] got, logic [31:0] want);
        if (errors < 40)
            $display("%0t: response mismatch on %s: got %h, expected %h",
                     $time, field, got, want);
        errors++;
    endtask

    task check_reply(lfuc_pkg::t_rsp got);
        lfuc_pkg::t_rsp want;
        if (replies_due.size() == 0) begin
            report("unexpected response", got.read_value, '0);
            return;
        end
        want = replies_due.pop_front();
        if (got.hit !== want.hit)
            report("hit", got.hit, want.hit);
        if (got.read_value !== want.read_value)
            report("read_value", got.read_value, want.read_value);
        if (got.evicted !== want.evicted)
            report("evicted", got.evicted, want.evicted);
        if (got.evicted_key !== want.evicted_key)
            report("evicted_key", got.evicted_key, want.evicted_key);
    endtask
endclass

module tb;
    localparam int SLOTS       = 16;
    localparam int COUNT_W     = 16;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 2 * SLOTS + 8;

    logic                           clk;
    logic                           rst_n;
    logic                           req_valid;
    logic                           req_stall;
    lfuc_pkg::t_req                 req_data;
    logic                           rsp_valid;
    logic                           rsp_stall;
    lfuc_pkg::t_rsp                 rsp_data;
    logic                           cfg_we;
    logic [lfuc_pkg::CAP_REG_W-1:0] cfg_wdata;

    cache_mirror mirror;
    bit          idle_on;
    bit          hold_rsp;
    int          quiet_cycles;

    lfu_cache_lru_tiebreak_top #(
        .CAPACITY   (SLOTS),
        .COUNT_BITS (COUNT_W)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (req_valid),
        .o_in_stall  (req_stall),
        .i_in_data   (req_data),
        .o_out_valid (rsp_valid),
        .i_out_stall (rsp_stall),
        .o_out_data  (rsp_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    always #4 clk = ~clk;

    // monitors and watchdog
    always @(posedge clk) begin
        if (!rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (req_valid && !req_stall) begin
                mirror.note_access(req_data);
                quiet_cycles = 0;
            end
            if (rsp_valid && !rsp_stall) begin
                mirror.check_reply(rsp_data);
                quiet_cycles = 0;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("tb failed");
                $finish;
            end
        end
    end

    // response-side stall: random bursts, plus one long hold on request
    initial begin
        rsp_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_rsp) begin
                rsp_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_rsp = 1'b0;
                rsp_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(negedge clk);
                rsp_stall <= 1'b0;
            end else begin
                rsp_stall <= 1'b0;
            end
        end
    end

    // called at a falling edge, returns at a falling edge after the request is taken
    task automatic push_req(lfuc_pkg::t_req r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        do @(posedge clk); while (req_stall);
        @(negedge clk);
    endtask

    task automatic push_op(logic op, logic [lfuc_pkg::KEY_W-1:0] k,
                           logic [lfuc_pkg::VAL_W-1:0] v);
        lfuc_pkg::t_req r;
        r.operation = op;
        r.key       = k;
        r.put_value = v;
        push_req(r);
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        while (mirror.outstanding() != 0) @(negedge clk);
    endtask

    task automatic write_capacity(logic [lfuc_pkg::CAP_REG_W-1:0] v);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we <= 1'b0;
        mirror.set_capacity(v);
    endtask

    task automatic random_phase(logic [lfuc_pkg::CAP_REG_W-1:0] cap, int n, bit idle, bit hold);
        logic [lfuc_pkg::KEY_W-1:0] pool[$];
        int                         psize;
        lfuc_pkg::t_req             r;
        write_capacity(cap);
        idle_on = idle;
        psize   = ((cap > SLOTS) ? SLOTS : cap) + 4;
        for (int i = 0; i < psize; i++)
            pool.push_back($urandom);
        for (int k = 0; k < n; k++) begin
            if (hold && k == n / 3)
                hold_rsp = 1'b1;
            r.operation = 1'($urandom_range(0, 1));
            // mostly keys from a small set so hits and evictions happen often
            if ($urandom_range(0, 9) < 8)
                r.key = pool[$urandom_range(0, psize - 1)];
            else
                r.key = $urandom;
            r.put_value = $urandom;
            push_req(r);
        end
    endtask

    initial begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req_data  = '0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        idle_on   = 1'b0;
        hold_rsp  = 1'b0;
        mirror    = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // extreme keys and values, update, misses, empty-store lookup
        idle_on = 1'b1;
        push_op(lfuc_pkg::OP_GET, 32'h0000_0000, 32'hFFFF_FFFF);
        push_op(lfuc_pkg::OP_PUT, 32'h8000_0000, 32'h7FFF_FFFF);
        push_op(lfuc_pkg::OP_PUT, 32'h7FFF_FFFF, 32'h8000_0000);
        push_op(lfuc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_op(lfuc_pkg::OP_PUT, 32'h0000_0000, 32'h0000_0000);
        push_op(lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);
        push_op(lfuc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h5555_5555);
        push_op(lfuc_pkg::OP_PUT, 32'hFFFF_FFFF, 32'h1234_5678);
        push_op(lfuc_pkg::OP_GET, 32'hFFFF_FFFF, 32'h0000_0000);
        push_op(lfuc_pkg::OP_GET, 32'h0000_0001, 32'h0000_0000);
        push_op(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);

        // capacity dropped below occupancy: each new key evicts one entry
        write_capacity(5'd2);
        push_op(lfuc_pkg::OP_PUT, 32'h5555_5555, 32'hAAAA_AAAA);
        push_op(lfuc_pkg::OP_PUT, 32'hAAAA_AAAA, 32'h5555_5555);
        push_op(lfuc_pkg::OP_PUT, 32'hAAAA_AAAA, 32'h0F0F_0F0F);
        push_op(lfuc_pkg::OP_GET, 32'h8000_0000, 32'h0000_0000);

        // capacity zero: puts change nothing, gets still work
        write_capacity(5'd0);
        push_op(lfuc_pkg::OP_PUT, 32'h0000_0000, 32'hDEAD_BEEF);
        push_op(lfuc_pkg::OP_PUT, 32'h0000_0033, 32'h0000_0033);
        push_op(lfuc_pkg::OP_GET, 32'h0000_0000, 32'h0000_0000);
        push_op(lfuc_pkg::OP_GET, 32'h0000_0033, 32'h0000_0000);

        // single entry
        write_capacity(5'd1);
        push_op(lfuc_pkg::OP_PUT, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
        push_op(lfuc_pkg::OP_GET, 32'h0F0F_0F0F, 32'h0000_0000);

        random_phase(5'd31, 120, 1'b1, 1'b0);
        random_phase(5'd16, 150, 1'b1, 1'b1);
        random_phase(5'd1,   80, 1'b1, 1'b0);
        random_phase(5'd5,  100, 1'b0, 1'b0);
        random_phase(5'd0,   60, 1'b1, 1'b0);
        random_phase(5'd17, 120, 1'b1, 1'b0);
        random_phase(5'd3,  100, 1'b1, 1'b0);
        random_phase(5'd8,  100, 1'b1, 1'b0);
        random_phase(5'd16, 100, 1'b0, 1'b0);

        drain();
        repeat (SETTLE) @(posedge clk);
        if (mirror.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule
